FILE: design/rrva_pkg.sv
// ----------------------------------------------------------------------------
// rrva_pkg: shared types and constants of the voice allocator
// Event and result beat types, queue entry, opcodes and the top-octave ROM.
// ----------------------------------------------------------------------------
package rrva_pkg;

  // event opcodes
  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  // result actions
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // most release beats reported per note-off
  localparam int MAX_REL = 16;

  // command queue depth (power of two, pointers wrap naturally)
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       operation;
    logic [6:0] note;
    logic [7:0] velocity;
  } in_t;

  typedef struct packed {
    logic        action;
    logic [3:0]  voice;
    logic [20:0] frequency_centihz;
    logic [7:0]  volume;
    logic        last;
  } out_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        op;
    logic [6:0]  note;
    logic [15:0] vol_prod;   // loudness times volume scale, before /255
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // frequencies of notes 116..127 in centihertz; lower octaves shift right
  function automatic logic [20:0] top_octave(input logic [3:0] slot);
    logic [20:0] f;
    case (slot)
      4'd0:    f = 21'd664487;
      4'd1:    f = 21'd704000;
      4'd2:    f = 21'd745862;
      4'd3:    f = 21'd790213;
      4'd4:    f = 21'd837201;
      4'd5:    f = 21'd886984;
      4'd6:    f = 21'd939727;
      4'd7:    f = 21'd995606;
      4'd8:    f = 21'd1054808;
      4'd9:    f = 21'd1117530;
      4'd10:   f = 21'd1183982;
      4'd11:   f = 21'd1254385;
      default: f = 21'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: design/rrva_front.sv
// ----------------------------------------------------------------------------
// rrva_front: event intake
// Registers input beats, holds the volume scale and forms the loudness
// product, then pushes a command into the queue.
// ----------------------------------------------------------------------------
module rrva_front import rrva_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  q_status_t   q_st_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic       in_valid_q, in_valid_d;
  in_t        in_q;
  logic [7:0] scale_q;
  logic [7:0] loud;
  logic       accept;

  // volume scale register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 8'd255;
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end

  // input register, freed when its command enters the queue
  assign push_o     = in_valid_q && !q_st_i.full;
  assign in_stall_o = in_valid_q && q_st_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (push_o) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // loudness: full above 127, else twice the velocity
  assign loud = in_q.velocity[7] ? 8'd255 : {in_q.velocity[6:0], 1'b0};

  assign cmd_o.op       = in_q.operation;
  assign cmd_o.note     = in_q.note;
  assign cmd_o.vol_prod = 16'(loud) * 16'(scale_q);

endmodule

FILE: design/rrva_queue.sv
// ----------------------------------------------------------------------------
// rrva_queue: command queue
// Small FIFO that decouples event intake from voice handling.
// ----------------------------------------------------------------------------
module rrva_queue import rrva_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  input  logic      pop_i,
  output cmd_t      cmd_o,
  output q_status_t q_st_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q;

  assign q_st_o.full  = (cnt_q == (QAW+1)'(QDEPTH));
  assign q_st_o.empty = (cnt_q == '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && q_st_o.full)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && q_st_o.empty)) else $error("queue pop while empty");

endmodule

FILE: design/rrva_back.sv
// ----------------------------------------------------------------------------
// rrva_back: voice table and result sequencer
// Allocates voices round robin on note-on, finds and releases matching
// voices on note-off, and drives the registered result channel.
// ----------------------------------------------------------------------------
module rrva_back import rrva_pkg::*; #(
  parameter int VOICES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  q_status_t q_st_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_t      out_data_o
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_REL  = 1'b1;

  logic              state_q, state_d;
  logic [VW-1:0]     ptr_q;
  logic [VOICES-1:0] vvalid_q;
  logic [6:0]        vnote_q [VOICES];
  logic [VOICES-1:0] mask_q, mask_d;
  logic [VOICES-1:0] match;
  logic [VOICES-1:0] pick;
  logic [VW-1:0]     pick_idx;
  logic [3:0]        cnt_q, cnt_d;
  logic              rel_last;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic              can_load;
  logic              take_on, take_off, emit_rel;

  // note to frequency: octave and slot of note+4 by reciprocal multiply
  logic [7:0]  nplus;
  logic [15:0] oct_prod;
  logic [3:0]  octave;
  logic [3:0]  slot;
  logic [20:0] freq;
  logic [7:0]  vol;

  assign nplus    = 8'(cmd_i.note) + 8'd4;
  assign oct_prod = 16'(nplus) * 16'd171;
  assign octave   = oct_prod[14:11];
  assign slot     = 4'(nplus - 8'(8'(octave) * 8'd12));
  assign freq     = top_octave(slot) >> (4'd10 - octave);

  // divide by 255: exact for 16-bit products
  assign vol = 8'((17'(cmd_i.vol_prod) + 17'd1 + 17'(cmd_i.vol_prod[15:8])) >> 8);

  // voices holding the note being released
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      match[i] = vvalid_q[i] && (vnote_q[i] == cmd_i.note);
    end
  end

  // lowest pending release
  always_comb begin
    pick_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (mask_q[i]) pick_idx = VW'(i);
    end
    pick = '0;
    pick[pick_idx] = mask_q[pick_idx];
  end

  assign rel_last = ((mask_q & ~pick) == '0) || (cnt_q == 4'(MAX_REL - 1));

  assign can_load = !out_valid_q || !out_stall_i;
  assign take_on  = (state_q == ST_IDLE) && !q_st_i.empty &&
                    (cmd_i.op == OP_NOTE_ON) && can_load;
  assign take_off = (state_q == ST_IDLE) && !q_st_i.empty &&
                    (cmd_i.op == OP_NOTE_OFF);
  assign emit_rel = (state_q == ST_REL) && can_load;
  assign pop_o    = take_on || take_off;

  // sequencer and output register next values
  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (take_on) begin
      out_valid_d             = 1'b1;
      out_d.action            = ACT_START;
      out_d.voice             = 4'(ptr_q);
      out_d.frequency_centihz = freq;
      out_d.volume            = vol;
      out_d.last              = 1'b1;
    end else if (take_off) begin
      mask_d = match;
      cnt_d  = '0;
      if (match != '0) state_d = ST_REL;
    end else if (emit_rel) begin
      out_valid_d             = 1'b1;
      out_d.action            = ACT_RELEASE;
      out_d.voice             = 4'(pick_idx);
      out_d.frequency_centihz = '0;
      out_d.volume            = '0;
      out_d.last              = rel_last;
      cnt_d                   = cnt_q + 4'd1;
      if (rel_last) begin
        mask_d  = '0;
        state_d = ST_IDLE;
      end else begin
        mask_d = mask_q & ~pick;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      vvalid_q    <= '0;
      mask_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (take_on) begin
        vvalid_q[ptr_q] <= 1'b1;
        ptr_q <= (ptr_q == VW'(VOICES - 1)) ? '0 : ptr_q + 1'b1;
      end else if (take_off) begin
        vvalid_q <= vvalid_q & ~match;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (take_on) begin
      vnote_q[ptr_q] <= cmd_i.note;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rel_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL) |-> (mask_q != '0)) else $error("release state with no match");

  a_rel_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL) |-> ((mask_q & vvalid_q) == '0))
    else $error("pending release on a live voice");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL) |-> !pop_o) else $error("queue pop during release burst");

endmodule

FILE: design/round_robin_voice_allocator_top.sv
// ----------------------------------------------------------------------------
// round_robin_voice_allocator_top: polyphonic voice allocator
// Input channel takes note-on/note-off beats; output channel gives start
// and release beats. A config write channel loads the volume scale.
//
// Input beats are taken when in_valid_i is high and in_stall_o low. An
// accepted beat sits in the intake register, moves into a two-entry
// command queue, and is handled by the voice sequencer one command at a
// time. A note-on's start beat passes the intake register, the queue and
// the output register; note-ons sustain one per cycle while out_stall_i
// is low. A note-off first compares all voices, then gives one release
// beat per matching voice per cycle while out_stall_i is low (at most
// 16); a note-off with no match gives no beat. Results sit in an output
// register; while out_stall_i is high a pending result holds, the
// sequencer gives no new beat, and intake keeps taking beats until the
// queue fills. cfg_ready_o is always high. Reset empties every voice,
// sets the round-robin pointer to voice 0 and the volume scale to 255.
// ----------------------------------------------------------------------------
module round_robin_voice_allocator_top import rrva_pkg::*; #(
  parameter int VOICES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  q_status_t q_st;
  cmd_t      push_cmd, pop_cmd;
  logic      push, pop;

  // intake and classification
  rrva_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_st_i      (q_st),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // command queue
  rrva_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .q_st_o (q_st)
  );

  // voice table and result sequencer
  rrva_back #(
    .VOICES (VOICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .q_st_i      (q_st),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
